// ===== sv/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

    // Default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Port field widths
    localparam int CMD_W        = 2;
    localparam int CHAR_W       = 8;
    localparam int ATTR_W       = 8;
    localparam int CELL_IDX_W   = 11;
    localparam int CURSOR_COL_W = 7;
    localparam int CURSOR_ROW_W = 5;
    localparam int CELL_W       = 16;

    // Character codes with special handling
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUT,
        S_WRITE,
        S_SCROLL_RD,
        S_SCROLL,
        S_FILL,
        S_READ,
        S_RESP
    } t_state;

endpackage

// ===== sv/tcw_cell_ram.sv =====
// Single-port-write, single-port-read cell store with registered read data.
`timescale 1ns / 1ps

module tcw_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/text_console_writer.sv =====
// Top level of the text console writer: command sequencer, cursor and cell store.
`timescale 1ns / 1ps

// Text console writer. Keeps a COLUMNS x ROWS store of 16-bit cells (attribute in
// the high byte, character in the low byte) and a cursor, and runs one command per
// input word: put character, clear screen or read one cell. Every command returns
// exactly one result word with the cursor after the step, the cell data
// (in-range reads only, zero otherwise) and a scrolled flag. The block takes one
// word at a time and drops ready until its result has been loaded into the output
// register; the output register lets the next word come in while a result still
// waits. Sequence from accept to result shown: a plain put, return, newline or
// backspace passes address multiply-add, store write and result load. A read
// passes store read and result load. A clear sweeps the store one cell per cycle
// through its single write port. A put that runs off the bottom row scrolls: the
// copy loop moves one cell per cycle through the one read and one write port,
// then the bottom row is blanked. After reset the store is swept to blanks with
// attribute 0x07, with ready low; the attribute register may be written
// meanwhile. Write the attribute only while idle.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // command word
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [CMD_W-1:0]        i_command,
    input  logic [CHAR_W-1:0]       i_char_code,
    input  logic [CELL_IDX_W-1:0]   i_cell_index,
    // result word
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [CURSOR_COL_W-1:0] o_cursor_column,
    output logic [CURSOR_ROW_W-1:0] o_cursor_row,
    output logic [CELL_W-1:0]       o_cell_data,
    output logic                    o_scrolled,
    // attribute register
    input  logic                    i_cfg_we,
    input  logic [ATTR_W-1:0]       i_cfg_wdata
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int AW    = $clog2(CELLS);

    localparam logic [CW-1:0] COL_LAST     = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROW_LAST     = RW'(ROWS - 1);
    localparam logic [AW-1:0] LAST_CELL    = AW'(CELLS - 1);
    localparam logic [AW-1:0] FIRST_BOTTOM = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] LAST_COPY    = AW'(CELLS - COLUMNS - 1);
    localparam logic [AW-1:0] ROW_STRIDE   = AW'(COLUMNS);
    localparam logic [AW-1:0] COPY_AHEAD   = AW'(COLUMNS + 1);

    // Sequencer and cursor state
    t_state              r_state, n_state;
    logic [AW-1:0]       r_addr, n_addr;
    logic [CELL_W-1:0]   r_fill, n_fill;
    logic [CW-1:0]       r_col, n_col;
    logic [RW-1:0]       r_row, n_row;
    logic                r_pending, n_pending;
    logic [ATTR_W-1:0]   r_attr;

    // Latched command word
    logic [CMD_W-1:0]      r_cmd, n_cmd;
    logic [CHAR_W-1:0]     r_char, n_char;
    logic [CELL_IDX_W-1:0] r_idx, n_idx;

    // Put step results
    logic [CELL_W-1:0]   r_wdata, n_wdata;
    logic                r_wr_en, n_wr_en;
    logic                r_scrolled, n_scrolled;

    // Output register
    logic                r_out_valid, n_out_valid;
    logic [CW-1:0]       r_out_col, n_out_col;
    logic [RW-1:0]       r_out_row, n_out_row;
    logic [CELL_W-1:0]   r_out_data, n_out_data;
    logic                r_out_scrolled, n_out_scrolled;

    // Store port signals
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [CELL_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [CELL_W-1:0]   ram_rdata;

    logic                in_acc;
    logic                idx_ok;
    logic [AW-1:0]       row_base;
    logic                row_inc;

    assign in_acc = i_in_valid && o_in_ready;
    assign idx_ok = 32'(r_idx) < 32'(CELLS);
    // Start of the cursor row: the one multiply of the put path
    assign row_base = AW'(32'(r_row) * 32'(COLUMNS));

    tcw_cell_ram #(
        .DEPTH (CELLS),
        .AW    (AW),
        .DW    (CELL_W)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Attribute reg; written by user only while idle or sweeping after reset; no check
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= RESET_ATTR;
        end else if (i_cfg_we) begin
            r_attr <= i_cfg_wdata;
        end
    end

    // State and control registers. Reset starts the blanking sweep at cell 0.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_addr      <= '0;
            r_fill      <= {RESET_ATTR, BLANK_CHAR};
            r_col       <= '0;
            r_row       <= '0;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_fill      <= n_fill;
            r_col       <= n_col;
            r_row       <= n_row;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd          <= n_cmd;
        r_char         <= n_char;
        r_idx          <= n_idx;
        r_wdata        <= n_wdata;
        r_wr_en        <= n_wr_en;
        r_scrolled     <= n_scrolled;
        r_out_col      <= n_out_col;
        r_out_row      <= n_out_row;
        r_out_data     <= n_out_data;
        r_out_scrolled <= n_out_scrolled;
    end

    // Sequencer: next state, store ports and cursor update
    always_comb begin
        n_state        = r_state;
        n_addr         = r_addr;
        n_fill         = r_fill;
        n_col          = r_col;
        n_row          = r_row;
        n_pending      = r_pending;
        n_cmd          = r_cmd;
        n_char         = r_char;
        n_idx          = r_idx;
        n_wdata        = r_wdata;
        n_wr_en        = r_wr_en;
        n_scrolled     = r_scrolled;
        n_out_col      = r_out_col;
        n_out_row      = r_out_row;
        n_out_data     = r_out_data;
        n_out_scrolled = r_out_scrolled;
        n_out_valid    = r_out_valid && !i_out_ready;
        ram_we         = 1'b0;
        ram_waddr      = r_addr;
        ram_wdata      = r_fill;
        ram_re         = 1'b0;
        ram_raddr      = r_addr;
        row_inc        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd      = i_command;
                    n_char     = i_char_code;
                    n_idx      = i_cell_index;
                    n_pending  = 1'b1;
                    n_scrolled = 1'b0;
                    case (t_cmd'(i_command))
                        CMD_PUT:   n_state = S_PUT;
                        CMD_CLEAR: begin
                            n_fill  = {r_attr, BLANK_CHAR};
                            n_addr  = '0;
                            n_col   = '0;
                            n_row   = '0;
                            n_state = S_FILL;
                        end
                        CMD_READ:  n_state = S_READ;
                        default:   n_state = S_RESP;
                    endcase
                end
            end

            // Work out the target cell, the word to write and the new cursor
            S_PUT: begin
                n_wr_en = 1'b0;
                case (r_char)
                    CH_NEWLINE: begin
                        n_col   = '0;
                        row_inc = 1'b1;
                    end
                    CH_RETURN: begin
                        n_col = '0;
                    end
                    CH_BACKSPACE: begin
                        if (r_col != '0) begin
                            n_col   = r_col - 1'b1;
                            n_addr  = row_base + AW'(r_col - 1'b1);
                            n_wdata = {r_attr, BLANK_CHAR};
                            n_wr_en = 1'b1;
                        end
                    end
                    default: begin
                        n_addr  = row_base + AW'(r_col);
                        n_wdata = {r_attr, r_char};
                        n_wr_en = 1'b1;
                        if (r_col == COL_LAST) begin
                            n_col   = '0;
                            row_inc = 1'b1;
                        end else begin
                            n_col = r_col + 1'b1;
                        end
                    end
                endcase
                // Run off the bottom row: hold the cursor on it and scroll
                if (row_inc) begin
                    if (r_row == ROW_LAST) begin
                        n_scrolled = 1'b1;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end
                n_state = S_WRITE;
            end

            S_WRITE: begin
                ram_we    = r_wr_en;
                ram_waddr = r_addr;
                ram_wdata = r_wdata;
                n_state   = r_scrolled ? S_SCROLL_RD : S_RESP;
            end

            // Prime the copy loop with the first cell of row 1
            S_SCROLL_RD: begin
                ram_re    = 1'b1;
                ram_raddr = ROW_STRIDE;
                n_addr    = '0;
                n_state   = S_SCROLL;
            end

            // Copy one cell up a row per cycle, reading one row ahead
            S_SCROLL: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                ram_wdata = ram_rdata;
                if (r_addr == LAST_COPY) begin
                    n_addr  = FIRST_BOTTOM;
                    n_fill  = {r_attr, BLANK_CHAR};
                    n_state = S_FILL;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_addr + COPY_AHEAD;
                    n_addr    = r_addr + 1'b1;
                end
            end

            // Blank cells up to the end of the store
            S_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                ram_wdata = r_fill;
                if (r_addr == LAST_CELL) begin
                    n_state = r_pending ? S_RESP : S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end

            S_READ: begin
                ram_re    = idx_ok;
                ram_raddr = AW'(r_idx);
                n_state   = S_RESP;
            end

            // Load the result once the output register is free
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid    = 1'b1;
                    n_out_col      = r_col;
                    n_out_row      = r_row;
                    n_out_scrolled = r_scrolled;
                    n_out_data     = (r_cmd == CMD_READ && idx_ok) ? ram_rdata : '0;
                    n_pending      = 1'b0;
                    n_state        = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_cursor_column = CURSOR_COL_W'(r_out_col);
    assign o_cursor_row    = CURSOR_ROW_W'(r_out_row);
    assign o_cell_data     = r_out_data;
    assign o_scrolled      = r_out_scrolled;

    // A word is never accepted while a previous one is still being worked on
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !r_pending)
        else $error("ready while a command is still pending");

    // Ready drops right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("ready held high after accept");

    // A scroll always leaves the cursor on the bottom row
    a_scroll_bottom_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_scrolled) |-> (r_out_row == ROW_LAST))
        else $error("scrolled result off the bottom row");

    // Cursor stays on the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= COL_LAST) && (r_row <= ROW_LAST))
        else $error("cursor left the screen");

endmodule
